>>> sv/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_MUL   = 3'd3,
        MODE_DIV   = 3'd4,
        MODE_CLEAR = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_FINISH
    } state_t;

    localparam int QW     = 32;     // Q16.16 word
    localparam int FRAC   = 16;
    localparam int DIVW   = QW + FRAC;
    localparam int WIDEW  = DIVW + 1;
    localparam int STEPW  = $clog2(DIVW);
    localparam int DEPTHW = 8;

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

endpackage

>>> sv/rpn_stack_calculator_core.sv
// Top level of the RPN stack calculator: stack memory, control and arithmetic.
//
// One command word is taken at a time; each gives exactly one result word. The stack
// sits in a single STACK_DEPTH x 32 memory with one write and one registered read port;
// the top entry is also held in a register so an operator reads only its left operand
// from memory. Push, clear, ignored modes and stack errors go from decode to finish;
// add, subtract and divide by zero pass through fetch, multiply also through its own
// state, and divide through the 48-step shift-subtract divider, one quotient bit per
// cycle. The memory needs no clearing pass after reset: only entries below the depth
// count are ever read. A finished result waits in the output register while the next
// command is accepted.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   mode,
    input  logic signed [rpn_pkg::QW-1:0] operand,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [rpn_pkg::QW-1:0] top_value,
    output logic [rpn_pkg::DEPTHW-1:0]   stack_depth,
    output logic [1:0]                   status
);
    import rpn_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    function automatic logic signed [QW-1:0] sat32(input logic signed [WIDEW-1:0] v);
        logic signed [QW-1:0] r;
        if (v > WIDEW'(Q_MAX))
            r = Q_MAX;
        else if (v < WIDEW'(Q_MIN))
            r = Q_MIN;
        else
            r = v[QW-1:0];
        return r;
    endfunction

    logic signed [QW-1:0] stack_mem [STACK_DEPTH];

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic signed [QW-1:0] operand_reg, operand_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [QW-1:0] top_reg, top_next;
    status_t              status_reg, status_next;
    logic signed [QW-1:0] rd_data_reg;
    logic signed [2*QW-1:0] prod_reg, prod_next;
    logic signed [WIDEW-1:0] wide_reg, wide_next;
    logic                 neg_reg, neg_next;
    logic [QW-1:0]        dvs_reg, dvs_next;
    logic [QW-1:0]        rem_reg, rem_next;
    logic [DIVW-1:0]      quo_reg, quo_next;
    logic [STEPW-1:0]     step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [QW-1:0] top_value_reg, top_value_next;
    logic [DEPTHW-1:0]    stack_depth_reg, stack_depth_next;
    status_t              status_out_reg, status_out_next;

    logic                 accept, out_free, finish, is_op, stack_full, too_few;
    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_raddr, mem_waddr;
    logic signed [QW-1:0] mem_wdata;
    logic [CW-1:0]        below_top;
    logic signed [QW:0]   sum_add, sum_sub;
    logic [QW-1:0]        lhs_mag;
    logic [QW+1:0]        trial;
    logic                 trial_ok;
    logic signed [WIDEW-1:0] wide_signed;
    logic signed [QW-1:0] result;

    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign is_op      = (mode_reg == MODE_ADD) || (mode_reg == MODE_SUB)
                     || (mode_reg == MODE_MUL) || (mode_reg == MODE_DIV);
    assign stack_full = (count_reg == CW'(STACK_DEPTH));
    assign too_few    = (count_reg < CW'(2));
    assign below_top  = count_reg - CW'(2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (is_op && !too_few)
                    state_next = S_FETCH;
                else
                    state_next = S_FINISH;
            end
            S_FETCH:
            begin
                if (mode_reg == MODE_MUL)
                    state_next = S_MUL;
                else if (mode_reg == MODE_DIV && top_reg != '0)
                    state_next = S_DIV;
                else
                    state_next = S_FINISH;
            end
            S_MUL:
            begin
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (step_reg == '0)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        mem_re    = (state_reg == S_DECODE) && is_op && !too_few;
        finish    = (state_reg == S_FINISH) && out_free;
    end

    // Datapath
    always_comb
    begin
        mode_next        = mode_reg;
        operand_next     = operand_reg;
        count_next       = count_reg;
        top_next         = top_reg;
        status_next      = status_reg;
        prod_next        = prod_reg;
        wide_next        = wide_reg;
        neg_next         = neg_reg;
        dvs_next         = dvs_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && out_stall;
        top_value_next   = top_value_reg;
        stack_depth_next = stack_depth_reg;
        status_out_next  = status_out_reg;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[AW-1:0];
        mem_wdata        = operand_reg;
        mem_raddr        = below_top[AW-1:0];

        sum_add     = {rd_data_reg[QW-1], rd_data_reg} + {top_reg[QW-1], top_reg};
        sum_sub     = {rd_data_reg[QW-1], rd_data_reg} - {top_reg[QW-1], top_reg};
        lhs_mag     = rd_data_reg[QW-1] ? (QW'(0) - rd_data_reg) : rd_data_reg;
        trial       = {1'b0, rem_reg, quo_reg[DIVW-1]} - {2'b00, dvs_reg};
        trial_ok    = !trial[QW+1];
        wide_signed = neg_reg ? -wide_reg : wide_reg;
        result      = sat32(wide_signed);

        if (accept)
        begin
            mode_next    = mode_t'(mode);
            operand_next = operand;
        end

        unique case (state_reg)
            S_DECODE:
            begin
                neg_next    = 1'b0;
                status_next = ST_OK;
                if (mode_reg == MODE_PUSH && stack_full)
                    status_next = ST_OVER;
                else if (is_op && too_few)
                    status_next = ST_UNDER;
            end
            S_FETCH:
            begin
                // rd_data_reg holds the left operand, top_reg the right one
                unique case (mode_reg)
                    MODE_ADD: wide_next = WIDEW'(sum_add);
                    MODE_SUB: wide_next = WIDEW'(sum_sub);
                    MODE_MUL: prod_next = rd_data_reg * top_reg;
                    MODE_DIV:
                    begin
                        if (top_reg == '0)
                            status_next = ST_DIVZ;
                        neg_next  = rd_data_reg[QW-1] ^ top_reg[QW-1];
                        dvs_next  = top_reg[QW-1] ? (QW'(0) - top_reg) : top_reg;
                        rem_next  = '0;
                        quo_next  = {lhs_mag, {FRAC{1'b0}}};
                        step_next = STEPW'(DIVW - 1);
                    end
                    default: ;
                endcase
            end
            S_MUL:
            begin
                // arithmetic shift rounds toward minus infinity
                wide_next = WIDEW'(prod_reg >>> FRAC);
            end
            S_DIV:
            begin
                rem_next  = trial_ok ? trial[QW-1:0] : {rem_reg[QW-2:0], quo_reg[DIVW-1]};
                quo_next  = {quo_reg[DIVW-2:0], trial_ok};
                step_next = step_reg - STEPW'(1);
                if (step_reg == '0)
                    wide_next = {1'b0, quo_next};
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    if (status_reg == ST_OK)
                    begin
                        if (mode_reg == MODE_PUSH)
                        begin
                            mem_we     = 1'b1;
                            top_next   = operand_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else if (is_op)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = below_top[AW-1:0];
                            mem_wdata  = result;
                            top_next   = result;
                            count_next = count_reg - CW'(1);
                        end
                        else if (mode_reg == MODE_CLEAR)
                        begin
                            count_next = '0;
                        end
                    end
                    out_valid_next   = 1'b1;
                    top_value_next   = (count_next != '0) ? top_next : '0;
                    stack_depth_next = DEPTHW'(count_next);
                    status_out_next  = status_reg;
                end
            end
            default: ;
        endcase
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= stack_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        operand_reg     <= operand_next;
        top_reg         <= top_next;
        status_reg      <= status_next;
        prod_reg        <= prod_next;
        wide_reg        <= wide_next;
        neg_reg         <= neg_next;
        dvs_reg         <= dvs_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
        top_value_reg   <= top_value_next;
        stack_depth_reg <= stack_depth_next;
        status_out_reg  <= status_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign stack_depth = stack_depth_reg;
    assign status      = status_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_divz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && status_reg == ST_DIVZ) |-> (mode_reg == MODE_DIV))
        else $error("divide-by-zero status on a non-divide word");

    a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && status_reg != ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("stack changed on an error word");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && status_reg == ST_OK && mode_reg == MODE_PUSH)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the stack");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the RPN stack calculator core.
`timescale 1ns / 100ps

module testbench;
    import rpn_pkg::*;

    localparam int STACK_DEPTH = 128;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;
    localparam int ITEM_TARGET = 750;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AT_A = 150;
    localparam int HOLD_AT_B = 520;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] operand;
        logic        drain;     // wait for all results to return first
    } command_t;

    typedef struct packed {
        logic [31:0] top;
        logic [7:0]  depth;
        logic [1:0]  status;
    } result_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           mode = 3'd0;
    logic signed [QW-1:0] operand = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [QW-1:0] top_value;
    logic [DEPTHW-1:0]    stack_depth;
    logic [1:0]           status;

    command_t command_queue[$];
    result_t  result_queue[$];

    // predictor state
    logic signed [31:0] stack_model [STACK_DEPTH];
    int                 depth_model = 0;
    int                 peak_depth = 0;

    int  n_planned = 0;
    int  n_sent = 0;
    int  n_results = 0;
    int  errors = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  drain_next = 1'b0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  rx_gap;

    rpn_stack_calculator_core #(.STACK_DEPTH(STACK_DEPTH)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .operand     (operand),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_value   (top_value),
        .stack_depth (stack_depth),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic signed [31:0] clamp_q(longint w);
        if (w > longint'(Q_MAX))
            return Q_MAX;
        if (w < longint'(Q_MIN))
            return Q_MIN;
        return w[31:0];
    endfunction

    // Applies one command word to the stack copy and returns the result word.
    function automatic result_t exec_command(logic [2:0] m, logic signed [31:0] v);
        result_t            r;
        logic signed [31:0] lhs;
        logic signed [31:0] rhs;
        longint             wide;
        bit                 done;
        r.status = ST_OK;
        wide = 0;
        done = 1'b1;
        case (m)
            MODE_PUSH:
            begin
                if (depth_model >= STACK_DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    stack_model[depth_model] = v;
                    depth_model++;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
            begin
                if (depth_model < 2)
                    r.status = ST_UNDER;
                else
                begin
                    rhs = stack_model[depth_model - 1];
                    lhs = stack_model[depth_model - 2];
                    case (m)
                        MODE_ADD: wide = longint'(lhs) + longint'(rhs);
                        MODE_SUB: wide = longint'(lhs) - longint'(rhs);
                        // arithmetic shift floors toward minus infinity
                        MODE_MUL: wide = (longint'(lhs) * longint'(rhs)) >>> FRAC;
                        default:
                        begin
                            if (rhs == 0)
                            begin
                                done = 1'b0;
                                r.status = ST_DIVZ;
                            end
                            else
                                wide = (longint'(lhs) * 65536) / longint'(rhs);
                        end
                    endcase
                    if (done)
                    begin
                        depth_model--;
                        stack_model[depth_model - 1] = clamp_q(wide);
                    end
                end
            end
            MODE_CLEAR: depth_model = 0;
            default: ;
        endcase
        if (depth_model > peak_depth)
            peak_depth = depth_model;
        r.top = (depth_model != 0) ? stack_model[depth_model - 1] : 32'd0;
        r.depth = depth_model[7:0];
        return r;
    endfunction

    task automatic add_cmd(logic [2:0] m, logic [31:0] v);
        command_t c;
        c.mode = m;
        c.operand = v;
        c.drain = drain_next;
        drain_next = 1'b0;
        command_queue.push_back(c);
        if (m <= MODE_CLEAR)
            n_planned++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = 32'h0001_0000;
                    3: v = 32'hFFFF_0000;
                    4: v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            5, 6: v = $urandom;
            7: v = 32'd0;
            8: v = ($urandom_range(0, 64) - 32) << 16;
            default: v = $urandom_range(0, 510) - 255;
        endcase
        return v;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Sender: offers the next word once the slot is free and its gap has run out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                result_queue.push_back(exec_command(mode, operand));
                n_sent++;
            end
            if (send_wait != 0)
            begin
                send_wait <= send_wait - 1;
                in_valid <= 1'b0;
            end
            else if (command_queue.size() != 0 &&
                     !(command_queue[0].drain && result_queue.size() != 0))
            begin
                mode <= command_queue[0].mode;
                operand <= command_queue[0].operand;
                in_valid <= 1'b1;
                void'(command_queue.pop_front());
                if ($urandom_range(0, 39) == 0)
                    tx_quiet <= !tx_quiet;
                send_wait <= tx_quiet ? 0 : $urandom_range(0, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: checks each result word and then stalls for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result, top %0d depth %0d status %0d",
                         $time, top_value, stack_depth, status);
                errors++;
            end
            else
            begin
                compare_field("top_value", $signed(result_queue[0].top), top_value);
                compare_field("stack_depth", result_queue[0].depth, stack_depth);
                compare_field("status", result_queue[0].status, status);
                void'(result_queue.pop_front());
            end
            status_seen[status]++;
            n_results++;
            if ($urandom_range(0, 29) == 0)
                rx_quiet = !rx_quiet;
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 16);
            // long hold-offs let the core back up and stall its input
            if (n_results == HOLD_AT_A || n_results == HOLD_AT_B)
                rx_gap = LONG_HOLD;
            recv_wait <= rx_gap;
            out_stall <= (rx_gap != 0);
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            out_stall <= (recv_wait > 1);
        end
    end

    initial
    begin
        int kind;
        int k;

        // directed: saturation corners, errors, rounding and ignored modes
        add_cmd(MODE_ADD, 32'd0);
        add_cmd(MODE_PUSH, Q_MAX);
        add_cmd(MODE_DIV, 32'd0);
        add_cmd(MODE_PUSH, Q_MAX);
        add_cmd(MODE_ADD, 32'd0);
        add_cmd(MODE_PUSH, Q_MIN);
        add_cmd(MODE_SUB, 32'd0);
        add_cmd(MODE_PUSH, Q_MIN);
        add_cmd(MODE_PUSH, 32'd1);
        add_cmd(MODE_SUB, 32'd0);
        add_cmd(MODE_MUL, 32'd0);
        add_cmd(MODE_PUSH, 32'd3);
        add_cmd(MODE_PUSH, 32'hFFFF_FFFF);
        add_cmd(MODE_MUL, 32'd0);
        add_cmd(MODE_PUSH, 32'd0);
        add_cmd(MODE_DIV, 32'd0);
        add_cmd(MODE_CLEAR, 32'd0);
        add_cmd(MODE_PUSH, Q_MIN);
        add_cmd(MODE_PUSH, 32'hFFFF_0000);
        add_cmd(MODE_DIV, 32'd0);
        add_cmd(MODE_PUSH, 32'd1);
        add_cmd(MODE_DIV, 32'd0);
        add_cmd(MODE_RSVD6, Q_MIN);
        add_cmd(MODE_RSVD7, Q_MAX);
        add_cmd(MODE_CLEAR, 32'd0);

        // fill to the top once, after a full drain
        drain_next = 1'b1;
        add_cmd(MODE_CLEAR, 32'd0);
        repeat (STACK_DEPTH + $urandom_range(1, 3))
            add_cmd(MODE_PUSH, pick_value());
        for (k = MODE_ADD; k <= MODE_DIV; k++)
            add_cmd(3'(k), 32'd0);
        add_cmd(MODE_CLEAR, 32'd0);

        while (n_planned < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                k = $urandom_range(2, 6);
                repeat (k)
                    add_cmd(MODE_PUSH, pick_value());
                repeat (k - 1)
                    add_cmd(3'($urandom_range(1, 4)), pick_value());
                if ($urandom_range(0, 9) == 0)
                    add_cmd(3'($urandom_range(1, 4)), pick_value());
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(10, 40))
                    add_cmd(MODE_PUSH, pick_value());
                repeat ($urandom_range(5, 40))
                    add_cmd(3'($urandom_range(1, 4)), pick_value());
            end
            else if (kind < 71)
            begin
                add_cmd(MODE_CLEAR, 32'd0);
                repeat (STACK_DEPTH + 1)
                    add_cmd(MODE_PUSH, pick_value());
            end
            else if (kind < 78)
                add_cmd(MODE_CLEAR, pick_value());
            else if (kind < 83)
                drain_next = 1'b1;
            else
            begin
                repeat ($urandom_range(1, 4))
                    add_cmd(3'($urandom_range(0, 7)), $urandom);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (command_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d command words sent, %0d results checked, peak depth %0d",
                 n_sent, n_results, peak_depth);
        $display("run: status ok %0d, overflow %0d, underflow %0d, divide by zero %0d",
                 status_seen[ST_OK], status_seen[ST_OVER], status_seen[ST_UNDER],
                 status_seen[ST_DIVZ]);
        if (errors == 0 && result_queue.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
